@@ rtl/core/wsm_pkg.sv @@
// Shared types, constants and helper functions for the wildcard substring matcher.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package wsm_pkg;

  // Default sizing
  localparam int PATTERN_MAX_DEF    = 8;
  localparam int POSITION_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int COUNT_W   = 16;
  localparam int INDEX_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration bus
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_LO = 3;   // registers sit on 8-byte boundaries

  // Character codes
  localparam logic [BYTE_W-1:0] CH_ANY     = 8'h25; // '%'
  localparam logic [BYTE_W-1:0] CH_DIGIT   = 8'h23; // '#'
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30; // '0'
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39; // '9'
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41; // 'A'
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A; // 'Z'
  localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20; // 'a' - 'A'

  typedef logic [BYTE_W-1:0] byte_t;

  // Register indexes
  typedef enum logic [1:0] {
    REG_PATTERN = 2'd0,
    REG_LENGTH  = 2'd1,
    REG_CASE    = 2'd2
  } reg_idx_t;

  // Register file contents
  typedef struct packed {
    logic [PAT_W-1:0] pattern_bytes;
    logic [LEN_W-1:0] pattern_length;
    logic             case_insensitive;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic               match_ends_here;
    logic [COUNT_W-1:0] match_count;
    logic               found;
    logic [INDEX_W-1:0] first_index;
    logic               text_done;
  } result_t;

  // Lowercase ASCII letters when folding is on
  function automatic byte_t fold_case(input byte_t c, input logic ci);
    byte_t r;
    r = c;
    if (ci && (c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      r = c + CASE_DIFF;
    end
    return r;
  endfunction

  // One pattern byte against one text byte, both already folded
  function automatic logic byte_match(input byte_t pat, input byte_t txt);
    logic is_digit;
    is_digit = (txt >= CH_ZERO) && (txt <= CH_NINE);
    return (pat == CH_ANY) || ((pat == CH_DIGIT) && is_digit) || (pat == txt);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/wsm_if.sv @@
// Valid/ready stream interfaces for the text input and the result output.
// Depends on wsm_pkg for field widths.
`default_nettype none

interface wsm_in_if;
  logic                  valid;
  logic                  ready;
  wsm_pkg::byte_t        text_byte;
  logic                  end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface wsm_out_if;
  logic                              valid;
  logic                              ready;
  logic                              match_ends_here;
  logic [wsm_pkg::COUNT_W-1:0]       match_count;
  logic                              found;
  logic [wsm_pkg::INDEX_W-1:0]       first_index;
  logic                              text_done;

  modport source (output valid, output match_ends_here, output match_count,
                  output found, output first_index, output text_done, input ready);
  modport sink   (input valid, input match_ends_here, input match_count,
                  input found, input first_index, input text_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wsm_cfg_regs.sv @@
// APB-style register file: pattern, pattern length, case fold flag.
// Depends on wsm_pkg.
`default_nettype none

module wsm_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [wsm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [wsm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [wsm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output wsm_pkg::cfg_t                          cfg
);

  wsm_pkg::cfg_t cfg_r;
  logic [1:0]    idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[wsm_pkg::CFG_IDX_LO +: 2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes    <= '0;
      cfg_r.pattern_length   <= wsm_pkg::LEN_W'(1);
      cfg_r.case_insensitive <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        wsm_pkg::REG_PATTERN: cfg_r.pattern_bytes    <= pwdata;
        wsm_pkg::REG_LENGTH:  cfg_r.pattern_length   <= pwdata[wsm_pkg::LEN_W-1:0];
        wsm_pkg::REG_CASE:    cfg_r.case_insensitive <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      wsm_pkg::REG_PATTERN: prdata = cfg_r.pattern_bytes;
      wsm_pkg::REG_LENGTH:  prdata = wsm_pkg::CFG_DATA_W'(cfg_r.pattern_length);
      wsm_pkg::REG_CASE:    prdata = wsm_pkg::CFG_DATA_W'(cfg_r.case_insensitive);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/wsm_window.sv @@
// Byte history line and the parallel wildcard compare of the pattern window.
// Depends on wsm_pkg.
`default_nettype none

module wsm_window #(
  parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEF,
  localparam int LW = $clog2(PATTERN_MAX + 1),
  localparam int HD = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire wsm_pkg::byte_t  cur_byte,
  input  wire logic            last,
  input  wire logic [LW-1:0]   eff_len,
  input  wire wsm_pkg::cfg_t   cfg,
  output logic                 window_ok
);

  localparam int SW = LW + 1;

  wsm_pkg::byte_t hist_r [HD];
  wsm_pkg::byte_t win    [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] lane_ok;

  // Window: slot 0 is the current byte, slot k the byte k places back
  always_comb begin
    win[0] = cur_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win[k] = hist_r[k-1];
    end
  end

  // Pattern byte j lines up with window slot len-1-j; lanes past len pass
  always_comb begin
    wsm_pkg::byte_t pat;
    wsm_pkg::byte_t txt;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pat = wsm_pkg::fold_case(cfg.pattern_bytes[8*j +: 8], cfg.case_insensitive);
      txt = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (SW'(k) + SW'(j) + SW'(1) == SW'(eff_len)) begin
          txt = win[k];
        end
      end
      txt = wsm_pkg::fold_case(txt, cfg.case_insensitive);
      lane_ok[j] = (SW'(j) >= SW'(eff_len)) || wsm_pkg::byte_match(pat, txt);
    end
  end

  assign window_ok = &lane_ok;

  // History shift line, cleared after the last byte of a text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HD; k++) hist_r[k] <= '0;
    end else if (fire) begin
      if (last) begin
        for (int k = 0; k < HD; k++) hist_r[k] <= '0;
      end else begin
        hist_r[0] <= cur_byte;
        for (int k = 1; k < HD; k++) hist_r[k] <= hist_r[k-1];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wsm_stats.sv @@
// Per-text position, match count, found flag and first start index.
// Depends on wsm_pkg; builds the result beat for the output register.
`default_nettype none

module wsm_stats #(
  parameter int PATTERN_MAX    = wsm_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_WIDTH = wsm_pkg::POSITION_WIDTH_DEF,
  localparam int LW = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic            last,
  input  wire logic [LW-1:0]   eff_len,
  input  wire logic            window_ok,
  output wsm_pkg::result_t     result
);

  localparam int PW = POSITION_WIDTH;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  logic [PW-1:0]               pos_r, first_r, first_nxt, span;
  logic [wsm_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        found_r, found_nxt;
  logic                        hit;

  // A match needs len bytes of the current text
  assign span = PW'(eff_len) - PW'(1);
  assign hit  = window_ok && (pos_r >= span);

  always_comb begin
    count_nxt = count_r;
    found_nxt = found_r;
    first_nxt = first_r;
    if (hit) begin
      if (count_r != wsm_pkg::COUNT_MAX) count_nxt = count_r + 1'b1;
      if (!found_r) begin
        found_nxt = 1'b1;
        first_nxt = pos_r - span;
      end
    end
  end

  always_comb begin
    result.match_ends_here = hit;
    result.match_count     = count_nxt;
    result.found           = found_nxt;
    result.first_index     = found_nxt ? wsm_pkg::INDEX_W'(first_nxt) : '0;
    result.text_done       = last;
  end

  // Update on each processed byte; clear after end of text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      found_r <= 1'b0;
      first_r <= '0;
    end else if (fire) begin
      if (last) begin
        pos_r   <= '0;
        count_r <= '0;
        found_r <= 1'b0;
        first_r <= '0;
      end else begin
        if (pos_r != POS_MAX) pos_r <= pos_r + 1'b1;
        count_r <= count_nxt;
        found_r <= found_nxt;
        first_r <= first_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wildcard_substring_matcher_top.sv @@
// Top level of the wildcard substring matcher: input register, window compare,
// statistics, result register and config registers. Depends on wsm_pkg, wsm_if,
// wsm_cfg_regs, wsm_window and wsm_stats.
//
//   Channel  Direction  Handshake            Beat contents
//   in_ch    sink       valid/ready          text_byte, end_of_text
//   out_ch   source     valid/ready          match_ends_here, match_count, found,
//                                            first_index, text_done
//   cfg_*    slave      APB psel/penable     pattern 0x00, length 0x08, case 0x10
//
// One byte per cycle sustained unless out_ch stalls; each byte passes the input
// register, then the result register behind the window compare.
// Reset (rst_n low, synchronous) clears valid flags, config registers, history and
// per-text state. A stall on out_ch holds the result register, then the input
// register, and only then drops in_ch.ready.
`default_nettype none

module wildcard_substring_matcher_top #(
  parameter int PATTERN_MAX    = wsm_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_WIDTH = wsm_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  wsm_in_if.sink                               in_ch,
  wsm_out_if.source                            out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [wsm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [wsm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [wsm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int LW = $clog2(PATTERN_MAX + 1);

  wsm_pkg::cfg_t    cfg;
  wsm_pkg::result_t result, out_r;
  wsm_pkg::byte_t   in_byte_r;
  logic             in_last_r, in_valid_r, out_valid_r;
  logic             s1_fire, window_ok;
  logic [LW-1:0]    eff_len;

  wsm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Clamp the pattern length to 1..PATTERN_MAX
  always_comb begin
    if (cfg.pattern_length == '0) begin
      eff_len = LW'(1);
    end else if (32'(cfg.pattern_length) > PATTERN_MAX) begin
      eff_len = LW'(PATTERN_MAX);
    end else begin
      eff_len = LW'(cfg.pattern_length);
    end
  end

  // Pipeline control
  assign s1_fire     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.text_byte;
      in_last_r <= in_ch.end_of_text;
    end
  end

  wsm_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .cur_byte  (in_byte_r),
    .last      (in_last_r),
    .eff_len   (eff_len),
    .cfg       (cfg),
    .window_ok (window_ok)
  );

  wsm_stats #(.PATTERN_MAX(PATTERN_MAX), .POSITION_WIDTH(POSITION_WIDTH)) u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .last      (in_last_r),
    .eff_len   (eff_len),
    .window_ok (window_ok),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.match_ends_here = out_r.match_ends_here;
  assign out_ch.match_count     = out_r.match_count;
  assign out_ch.found           = out_r.found;
  assign out_ch.first_index     = out_r.first_index;
  assign out_ch.text_done       = out_r.text_done;

  // Checks
  a_found_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.found == (out_r.match_count != '0)))
    else $error("found flag disagrees with match count");

  a_hit_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.match_ends_here) |-> out_r.found)
    else $error("match reported without found flag");

  a_index_zero_unfound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.first_index == '0))
    else $error("first index nonzero before any match");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !s1_fire) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_last_r)))
    else $error("input register lost a pending byte");

endmodule

`default_nettype wire

@@ tb/sv/tb_wildcard_substring_matcher_top.sv @@
// Self-checking testbench for wildcard_substring_matcher_top: a directed table and
// random texts seeded with pattern instances, checked beat by beat against a local
// predictor or a row's given result. Depends on wsm_pkg, wsm_if and the RTL.
module tb_wildcard_substring_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE = 2'd3;  // decodes to no register
  localparam int unsigned SEGMENTS = 20;
  localparam int unsigned SEG_BEATS = 95;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        reg_sel;
    logic [63:0]       value;     // register data, or the text byte in [7:0]
    logic              eot;
    logic              has_exp;
    wsm_pkg::result_t  want;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [wsm_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [wsm_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [wsm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  wsm_in_if  in_bus ();
  wsm_out_if out_bus ();

  wildcard_substring_matcher_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow registers
  logic [63:0] pat_reg;
  logic [3:0]  len_reg;
  logic        nocase_reg;

  // Per-text search state
  wsm_pkg::byte_t text_window [7];
  logic [15:0]    text_pos;
  logic [15:0]    hit_count;
  logic [15:0]    first_hit;
  logic           hit_seen;

  wsm_pkg::result_t expected_results [$];
  wsm_pkg::byte_t   planted [$];
  int unsigned      mismatch_count;
  int unsigned      src_gap_pct;
  int unsigned      sink_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic wsm_pkg::byte_t lower_ascii(wsm_pkg::byte_t c);
    if (nocase_reg && c >= wsm_pkg::CH_UPPER_A && c <= wsm_pkg::CH_UPPER_Z) begin
      return c + wsm_pkg::CASE_DIFF;
    end
    return c;
  endfunction

  function automatic logic pattern_byte_hits(wsm_pkg::byte_t p, wsm_pkg::byte_t t);
    if (p == wsm_pkg::CH_ANY) begin
      return 1'b1;
    end
    if (p == wsm_pkg::CH_DIGIT && t >= wsm_pkg::CH_ZERO && t <= wsm_pkg::CH_NINE) begin
      return 1'b1;
    end
    return p == t;
  endfunction

  // Register value clamped into 1..8
  function automatic int unsigned active_len();
    if (len_reg == 4'd0) begin
      return 1;
    end
    if (len_reg > 4'd8) begin
      return 8;
    end
    return int'(len_reg);
  endfunction

  function automatic void clear_text();
    foreach (text_window[k]) text_window[k] = 8'h00;
    text_pos  = '0;
    hit_count = '0;
    first_hit = '0;
    hit_seen  = 1'b0;
  endfunction

  // Consumes one text byte and returns the beat it should produce
  function automatic wsm_pkg::result_t match_next_byte(wsm_pkg::byte_t b, logic e);
    int unsigned      n;
    int unsigned      back;
    logic             hit;
    wsm_pkg::byte_t   t;
    wsm_pkg::result_t r;
    n = active_len();
    hit = 1'b0;
    if (text_pos >= 16'(n - 1)) begin
      hit = 1'b1;
      for (int unsigned j = 0; j < n; j++) begin
        back = n - 1 - j;
        t = (back == 0) ? b : text_window[back - 1];
        if (!pattern_byte_hits(lower_ascii(pat_reg[8*j +: 8]), lower_ascii(t))) begin
          hit = 1'b0;
        end
      end
    end
    if (hit) begin
      if (hit_count != 16'hFFFF) begin
        hit_count++;
      end
      if (!hit_seen) begin
        hit_seen  = 1'b1;
        first_hit = text_pos - 16'(n - 1);
      end
    end
    r.match_ends_here = hit;
    r.match_count     = hit_count;
    r.found           = hit_seen;
    r.first_index     = hit_seen ? first_hit : 16'd0;
    r.text_done       = e;
    if (e) begin
      clear_text();
    end else begin
      for (int k = 6; k > 0; k--) text_window[k] = text_window[k - 1];
      text_window[0] = b;
      if (text_pos != 16'hFFFF) begin
        text_pos++;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    wsm_pkg::result_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $error("result beat with no expectation pending");
      end else begin
        want = expected_results.pop_front();
        check_field("match_ends_here", 16'(want.match_ends_here), 16'(out_bus.match_ends_here));
        check_field("match_count", want.match_count, out_bus.match_count);
        check_field("found", 16'(want.found), 16'(out_bus.found));
        check_field("first_index", want.first_index, out_bus.first_index);
        check_field("text_done", 16'(want.text_done), 16'(out_bus.text_done));
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input wsm_pkg::byte_t b, input logic e, input logic typed,
                           input wsm_pkg::result_t want);
    wsm_pkg::result_t pred;
    while ($urandom_range(99) < src_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.text_byte   <= b;
    in_bus.end_of_text <= e;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    pred = match_next_byte(b, e);
    expected_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Stop sending and let the pipeline empty, with margin after the last expected beat
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write: setup, then access until pready
  task automatic write_reg(input logic [1:0] sel, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= wsm_pkg::CFG_ADDR_W'(sel) << wsm_pkg::CFG_IDX_LO;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    case (sel)
      wsm_pkg::REG_PATTERN: pat_reg    = value;
      wsm_pkg::REG_LENGTH:  len_reg    = value[3:0];
      wsm_pkg::REG_CASE:    nocase_reg = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic script_row_t beat_row(wsm_pkg::byte_t b, logic e);
    script_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.value[7:0] = b;
    r.eot = e;
    return r;
  endfunction

  function automatic script_row_t checked_row(wsm_pkg::byte_t b, logic e, logic hit,
                                              logic [15:0] cnt, logic fnd,
                                              logic [15:0] start);
    script_row_t r;
    r = beat_row(b, e);
    r.has_exp = 1'b1;
    r.want.match_ends_here = hit;
    r.want.match_count     = cnt;
    r.want.found           = fnd;
    r.want.first_index     = start;
    r.want.text_done       = e;
    return r;
  endfunction

  function automatic script_row_t write_row(logic [1:0] sel, logic [63:0] value);
    script_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_sel = sel;
    r.value = value;
    return r;
  endfunction

  // Mix of wildcards, letters of both cases, digits and arbitrary bytes
  function automatic wsm_pkg::byte_t pick_sym();
    case ($urandom_range(5))
      0: return wsm_pkg::CH_ANY;
      1: return wsm_pkg::CH_DIGIT;
      2: return wsm_pkg::byte_t'("a") + wsm_pkg::byte_t'($urandom_range(2));
      3: return wsm_pkg::byte_t'("A") + wsm_pkg::byte_t'($urandom_range(2));
      4: return wsm_pkg::CH_ZERO + wsm_pkg::byte_t'($urandom_range(9));
      default: return wsm_pkg::byte_t'($urandom);
    endcase
  endfunction

  // Queue a text run that satisfies the current pattern, now and then spoiled
  function automatic void plant_instance();
    wsm_pkg::byte_t p;
    wsm_pkg::byte_t t;
    for (int unsigned j = 0; j < active_len(); j++) begin
      p = pat_reg[8*j +: 8];
      if (p == wsm_pkg::CH_ANY) begin
        t = pick_sym();
      end else if (p == wsm_pkg::CH_DIGIT) begin
        t = ($urandom_range(10) == 10) ? wsm_pkg::CH_DIGIT :
            wsm_pkg::CH_ZERO + wsm_pkg::byte_t'($urandom_range(9));
      end else begin
        t = p;
        if (nocase_reg && $urandom_range(1) == 1 &&
            ((t >= "a" && t <= "z") ||
             (t >= wsm_pkg::CH_UPPER_A && t <= wsm_pkg::CH_UPPER_Z))) begin
          t = t ^ wsm_pkg::CASE_DIFF;
        end
      end
      if ($urandom_range(7) == 0) begin
        t = pick_sym();
      end
      planted.push_back(t);
    end
  endfunction

  function automatic int unsigned new_text_len();
    return ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
  endfunction

  initial begin
    script_row_t      script [$];
    logic [63:0]      pat;
    logic [3:0]       len;
    int unsigned      text_left;
    wsm_pkg::byte_t   b;

    // Known levels from time zero
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.text_byte   = '0;
    in_bus.end_of_text = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    src_gap_pct        = 0;
    sink_stall_pct     = 0;
    mismatch_count     = 0;
    pat_reg            = '0;
    len_reg            = 4'd1;
    nocase_reg         = 1'b0;
    clear_text();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    script = {
      // reset pattern is a single zero byte
      checked_row(8'h00, 1'b0, 1'b1, 16'd1, 1'b1, 16'd0),
      checked_row(8'hFF, 1'b1, 1'b0, 16'd1, 1'b1, 16'd0),
      // "a#%" folded, three bytes
      write_row(wsm_pkg::REG_PATTERN,
                {40'h0, wsm_pkg::CH_ANY, wsm_pkg::CH_DIGIT, 8'h61}),
      write_row(wsm_pkg::REG_LENGTH, 64'd3),
      write_row(wsm_pkg::REG_CASE, 64'd1),
      // text shorter than the pattern never matches
      checked_row("A", 1'b0, 1'b0, 16'd0, 1'b0, 16'd0),
      checked_row("7", 1'b1, 1'b0, 16'd0, 1'b0, 16'd0),
      beat_row("x", 1'b0), beat_row("A", 1'b0), beat_row("7", 1'b0),
      beat_row("q", 1'b0), beat_row("#", 1'b1),
      // hash wildcard also takes a literal hash
      beat_row("a", 1'b0), beat_row("#", 1'b0), beat_row("#", 1'b1),
      write_row(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF),
      // length zero acts as one
      write_row(wsm_pkg::REG_PATTERN, 64'h5A),
      write_row(wsm_pkg::REG_LENGTH, 64'd0),
      beat_row("z", 1'b0), beat_row("Z", 1'b1),
      write_row(wsm_pkg::REG_CASE, 64'd0),
      beat_row("z", 1'b0), beat_row("Z", 1'b1),
      // length above eight acts as eight
      write_row(wsm_pkg::REG_PATTERN, {8{wsm_pkg::CH_ANY}}),
      write_row(wsm_pkg::REG_LENGTH, 64'd15),
      beat_row(8'hFF, 1'b0), beat_row(8'h00, 1'b0), beat_row(8'hFF, 1'b0),
      beat_row(8'h00, 1'b0), beat_row(8'hFF, 1'b0), beat_row(8'h00, 1'b0),
      beat_row(8'hFF, 1'b0),
      checked_row(8'h00, 1'b1, 1'b1, 16'd1, 1'b1, 16'd0)
    };
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(script[i].reg_sel, script[i].value);
      end else begin
        send_beat(script[i].value[7:0], script[i].eot, script[i].has_exp, script[i].want);
      end
    end

    // Random texts under changing settings; texts may span a settings change
    text_left = new_text_len();
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      case (seg / 5)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 46; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 46; end
        default: begin src_gap_pct = 31; sink_stall_pct = 31; end
      endcase
      if ($urandom_range(7) == 0) begin
        pat = {$urandom, $urandom};
      end else begin
        for (int j = 0; j < 8; j++) pat[8*j +: 8] = pick_sym();
      end
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: len = 4'd0;
          1: len = 4'd1;
          2: len = 4'd8;
          default: len = 4'd15;
        endcase
      end else begin
        len = 4'($urandom_range(1, 8));
      end
      write_reg(wsm_pkg::REG_PATTERN, pat);
      write_reg(wsm_pkg::REG_LENGTH, 64'(len));
      write_reg(wsm_pkg::REG_CASE, 64'($urandom_range(1)));
      planted.delete();
      for (int unsigned i = 0; i < SEG_BEATS; i++) begin
        if (planted.size() == 0 && $urandom_range(2) == 0) begin
          plant_instance();
        end
        b = (planted.size() != 0) ? planted.pop_front() : pick_sym();
        send_beat(b, text_left == 1, 1'b0, '0);
        text_left--;
        if (text_left == 0) begin
          text_left = new_text_len();
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
